// ===== hw/rtl/asmd_pkg.sv =====
package asmd_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int STEPS_PER_STAGE = 4;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

endpackage

// ===== hw/rtl/asmd_stage.sv =====
// One pipeline stage: STEPS restoring-divide steps or STEPS shift-add
// multiply steps, chosen by the command, on the word held in this stage.
module asmd_stage import asmd_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF,
	parameter int STEPS = STEPS_PER_STAGE,
	parameter int BASE  = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld_in,
	input  logic [1:0]           cmd_in,
	input  logic [WIDTH-1:0]     a_in,
	input  logic [WIDTH-1:0]     b_in,
	input  logic [2*WIDTH-1:0]   acc_in,
	input  logic [WIDTH-1:0]     q_in,
	input  logic                 zero_in,
	output logic                 vld_out,
	output logic [1:0]           cmd_out,
	output logic [WIDTH-1:0]     a_out,
	output logic [WIDTH-1:0]     b_out,
	output logic [2*WIDTH-1:0]   acc_out,
	output logic [WIDTH-1:0]     q_out,
	output logic                 zero_out
);
	logic [2*WIDTH-1:0] acc_n;
	logic [WIDTH-1:0]   q_n;
	logic [WIDTH-1:0]   ra, t;

	// For divide acc[WIDTH-1:0] is A; for multiply acc is the partial product.
	always_comb begin
		acc_n = acc_in;
		q_n   = q_in;
		for (int i = 0; i < STEPS; i++) begin
			if (BASE + i < WIDTH) begin
				if (cmd_in == CMD_DIV) begin
					ra = {acc_n[WIDTH-2:0], q_n[WIDTH-1]};
					q_n = {q_n[WIDTH-2:0], 1'b0};
					t = ra - b_in;
					if (!t[WIDTH-1]) begin
						ra = t;
						q_n[0] = 1'b1;
					end
					acc_n = {{WIDTH{1'b0}}, ra};
				end else begin
					ra = '0;
					t  = '0;
					if (b_in[BASE+i])
						acc_n = acc_n + ({{WIDTH{1'b0}}, a_in} << (BASE + i));
				end
			end else begin
				ra = '0;
				t  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_out  <= cmd_in;
			a_out    <= a_in;
			b_out    <= b_in;
			acc_out  <= acc_n;
			q_out    <= q_n;
			zero_out <= zero_in;
		end
	end
endmodule

// ===== hw/rtl/add_sub_mul_div_unit_core.sv =====
// Pipeline: an accepted input word passes the ceil(WIDTH/4) asmd_stage registers,
// with 4 multiply/divide steps per stage, and then the output register.
// Throughput: one word per cycle; the whole pipe advances when the output
// register is empty or being taken, so a stall holds every stage.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module add_sub_mul_div_unit_core import asmd_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic [WIDTH-1:0]     operand_a,
	input  logic [WIDTH-1:0]     operand_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2*WIDTH-1:0]   primary_result,
	output logic [WIDTH-1:0]     remainder
);
	localparam int NST = (WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	logic                 en;
	logic                 vld [NST+1];
	logic [1:0]           cmd [NST+1];
	logic [WIDTH-1:0]     a   [NST+1];
	logic [WIDTH-1:0]     b   [NST+1];
	logic [2*WIDTH-1:0]   acc [NST+1];
	logic [WIDTH-1:0]     q   [NST+1];
	logic                 zr  [NST+1];
	logic [2*WIDTH-1:0]   prim_n;
	logic [WIDTH-1:0]     rem_n;

	// Single global enable: pipe moves when the output slot frees up.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 0 inputs: divide seeds A with the dividend's sign extension.
	assign vld[0] = in_valid;
	assign cmd[0] = command;
	assign a[0]   = operand_a;
	assign b[0]   = operand_b;
	assign acc[0] = (command == CMD_DIV) ?
		{{WIDTH{1'b0}}, {WIDTH{operand_a[WIDTH-1]}}} : '0;
	assign q[0]   = operand_a;
	assign zr[0]  = (operand_a == '0);

	for (genvar s = 0; s < NST; s++) begin : g_st
		asmd_stage #(
			.WIDTH(WIDTH), .STEPS(STEPS_PER_STAGE), .BASE(s * STEPS_PER_STAGE)
		) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vld[s]), .cmd_in(cmd[s]), .a_in(a[s]), .b_in(b[s]),
			.acc_in(acc[s]), .q_in(q[s]), .zero_in(zr[s]),
			.vld_out(vld[s+1]), .cmd_out(cmd[s+1]), .a_out(a[s+1]),
			.b_out(b[s+1]), .acc_out(acc[s+1]), .q_out(q[s+1]),
			.zero_out(zr[s+1])
		);
	end

	// Final select: add/sub are one wide add or subtract on the carried operands.
	always_comb begin
		rem_n = '0;
		case (cmd[NST])
			CMD_ADD: prim_n = {{(WIDTH-1){1'b0}},
				{1'b0, a[NST]} + {1'b0, b[NST]}};
			CMD_SUB: prim_n = {{(WIDTH-1){1'b0}},
				{1'b1, a[NST]} - {1'b0, b[NST]}};
			CMD_MUL: prim_n = acc[NST];
			CMD_DIV: begin
				prim_n = zr[NST] ? '0 : {{WIDTH{1'b0}}, q[NST]};
				rem_n  = zr[NST] ? '0 : acc[NST][WIDTH-1:0];
			end
			default: prim_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			primary_result <= prim_n;
			remainder      <= rem_n;
		end
	end

`ifndef ASSERT_OFF
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(primary_result))
		else $error("output word changed under stall");
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld[NST] && cmd[NST] != CMD_DIV |=> remainder == '0)
		else $error("nonzero remainder for non-divide");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
`endif
endmodule
